/* sv/szsl_pkg.sv */
// szsl_pkg: shared widths, constants, register indexes and types for the
// safe-zone stop level unit. no dependencies; used by szsl_if, szsl_div and safezone_stop_level_unit.
package szsl_pkg;

    localparam int MAX_DROP_WINDOW = 64;
    localparam int MAX_MAX_WINDOW  = 16;
    localparam int DROP_AW         = $clog2(MAX_DROP_WINDOW);
    localparam int CAND_AW         = $clog2(MAX_MAX_WINDOW);

    localparam int PRICE_W  = 32;
    localparam int DW_W     = 7;
    localparam int MW_W     = 5;
    localparam int MULT_W   = 16;
    localparam int CFG_W    = 16;
    localparam int SUM_W    = 38;
    localparam int COUNT_W  = 7;
    localparam int PROD_W   = MULT_W + SUM_W;
    localparam int FRAC_SH  = 8;
    localparam int QUO_W    = PROD_W - FRAC_SH;
    localparam int DIV_CW   = $clog2(QUO_W);
    localparam int SCOUNT_W = 7;

    localparam logic [DW_W-1:0]     DROP_WINDOW_RST = 7'd10;
    localparam logic [MW_W-1:0]     MAX_WINDOW_RST  = 5'd3;
    localparam logic [MULT_W-1:0]   MULTIPLIER_RST  = 16'd512;
    localparam logic [SCOUNT_W-1:0] SAMPLE_LIMIT    = SCOUNT_W'(MAX_DROP_WINDOW + MAX_MAX_WINDOW);
    localparam logic [DW_W-1:0]     DROP_WIN_LO     = 7'd2;
    localparam logic [DW_W-1:0]     DROP_WIN_HI     = DW_W'(MAX_DROP_WINDOW);
    localparam logic [MW_W-1:0]     MAX_WIN_LO      = 5'd1;
    localparam logic [MW_W-1:0]     MAX_WIN_HI      = MW_W'(MAX_MAX_WINDOW);

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_DROP_WINDOW = 2'd0;
    localparam cfg_index_t REG_MAX_WINDOW  = 2'd1;
    localparam cfg_index_t REG_MULTIPLIER  = 2'd2;

    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [QUO_W-1:0]   quo_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* sv/szsl_if.sv */
// szsl_if: valid/ready channels for price samples and stop level results.
// depends on szsl_pkg.
interface szsl_sample_if;
    logic                  valid;
    logic                  ready;
    szsl_pkg::price_t      price;
    logic                  series_start;

    modport source (output valid, output price, output series_start, input ready);
    modport sink   (input valid, input price, input series_start, output ready);
endinterface

interface szsl_stop_if;
    logic                  valid;
    logic                  ready;
    szsl_pkg::price_t      stop_level;
    logic                  ready_res;

    modport source (output valid, output stop_level, output ready_res, input ready);
    modport sink   (input valid, input stop_level, input ready_res, output ready);
endinterface

/* sv/szsl_ram.sv */
// szsl_ram: generic single-write, single-read ram with registered read data.
// no dependencies.
module szsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/szsl_div.sv */
// szsl_div: restoring divider, one quotient bit per cycle.
// depends on szsl_pkg.
module szsl_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  szsl_pkg::quo_t        dividend,
    input  szsl_pkg::count_t      divisor,
    output szsl_pkg::quo_t        quotient,
    output szsl_pkg::div_status_t status
);
    import szsl_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    quo_t              quo_reg, quo_next;
    count_t            rem_reg, rem_next;
    logic [COUNT_W:0]  shifted;
    logic [COUNT_W:0]  diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = shifted >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[QUO_W-2:0], ge};
            rem_next = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* sv/safezone_stop_level_unit.sv */
// safezone_stop_level_unit: one sample at a time; the next sample beat is taken only
// once the result register is loaded, and later while a result waits. the divider is
// skipped when no drop lies in the window. the drop walk reads one ram entry a cycle,
// the divider yields one quotient bit a cycle, the maximum walks the candidate ram.
// reset restores the register defaults and clears all history.
module safezone_stop_level_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    szsl_sample_if.sink          samples,
    szsl_stop_if.source          stops,
    input  logic                 cfg_wr_en,
    input  szsl_pkg::cfg_index_t cfg_index,
    input  szsl_pkg::cfg_data_t  cfg_data
);
    import szsl_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SUM       = 4'd1;
    localparam logic [3:0] S_SUM_DRAIN = 4'd2;
    localparam logic [3:0] S_MUL       = 4'd3;
    localparam logic [3:0] S_DIV_GO    = 4'd4;
    localparam logic [3:0] S_DIV       = 4'd5;
    localparam logic [3:0] S_CAND      = 4'd6;
    localparam logic [3:0] S_MAX       = 4'd7;
    localparam logic [3:0] S_MAX_DRAIN = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [DW_W-1:0]      drop_window_reg;
    logic [MW_W-1:0]      max_window_reg;
    logic [MULT_W-1:0]    multiplier_reg;

    price_t               last_price_reg, last_price_next;
    logic [DROP_AW-1:0]   drop_wp_reg, drop_wp_next;
    logic [CAND_AW-1:0]   cand_wp_reg, cand_wp_next;
    logic [MAX_DROP_WINDOW-1:0] drop_valid_reg, drop_valid_next;
    logic [MAX_MAX_WINDOW-1:0]  cand_valid_reg, cand_valid_next;
    logic [SCOUNT_W-1:0]  sample_count_reg, sample_count_next;
    logic [DROP_AW-1:0]   iter_reg, iter_next;
    logic                 acc_en_reg, acc_en_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 out_valid_reg, out_valid_next;

    price_t               price_reg, price_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    count_t               count_reg, count_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    price_t               best_reg, best_next;
    price_t               out_stop_reg, out_stop_next;
    logic                 out_rdy_reg, out_rdy_next;

    logic [DW_W-1:0]      n1_eff;
    logic [MW_W-1:0]      n2_eff;
    logic                 accept;
    logic                 series_ready;

    logic                 drop_we;
    logic [DROP_AW-1:0]   drop_waddr, drop_raddr;
    price_t               drop_wdata, drop_rdata;
    logic                 cand_we;
    logic [CAND_AW-1:0]   cand_raddr;
    price_t               cand_wdata, cand_rdata;

    logic                 div_start;
    quo_t                 quotient;
    div_status_t          div_status;

    price_t               rd_word;
    price_t               drop_val;
    logic [SCOUNT_W-1:0]  sc_eff;

    szsl_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_DROP_WINDOW)) u_drop_ram (
        .clk   (clk),
        .we    (drop_we),
        .waddr (drop_waddr),
        .wdata (drop_wdata),
        .raddr (drop_raddr),
        .rdata (drop_rdata)
    );

    szsl_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_MAX_WINDOW)) u_cand_ram (
        .clk   (clk),
        .we    (cand_we),
        .waddr (cand_wp_reg),
        .wdata (cand_wdata),
        .raddr (cand_raddr),
        .rdata (cand_rdata)
    );

    szsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[PROD_W-1:FRAC_SH]),
        .divisor  (count_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    // effective windows
    always_comb
    begin
        if (drop_window_reg < DROP_WIN_LO)
            n1_eff = DROP_WIN_LO;
        else if (drop_window_reg > DROP_WIN_HI)
            n1_eff = DROP_WIN_HI;
        else
            n1_eff = drop_window_reg;
        if (max_window_reg < MAX_WIN_LO)
            n2_eff = MAX_WIN_LO;
        else if (max_window_reg > MAX_WIN_HI)
            n2_eff = MAX_WIN_HI;
        else
            n2_eff = max_window_reg;
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign series_ready  = {1'b0, sample_count_reg} >=
                           ({1'b0, n1_eff} + {3'b0, n2_eff} - 8'd1);
    assign drop_raddr    = drop_wp_reg - 1'b1 - iter_reg;
    assign cand_raddr    = cand_wp_reg - 1'b1 - iter_reg[CAND_AW-1:0];

    always_comb
    begin
        state_next        = state_reg;
        last_price_next   = last_price_reg;
        drop_wp_next      = drop_wp_reg;
        cand_wp_next      = cand_wp_reg;
        drop_valid_next   = drop_valid_reg;
        cand_valid_next   = cand_valid_reg;
        sample_count_next = sample_count_reg;
        iter_next         = iter_reg;
        acc_en_next       = 1'b0;
        rd_valid_next     = 1'b0;
        out_valid_next    = out_valid_reg;
        price_next        = price_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        prod_next         = prod_reg;
        best_next         = best_reg;
        out_stop_next     = out_stop_reg;
        out_rdy_next      = out_rdy_reg;
        drop_we           = 1'b0;
        drop_waddr        = drop_wp_reg;
        drop_wdata        = '0;
        cand_we           = 1'b0;
        cand_wdata        = '0;
        div_start         = 1'b0;
        rd_word           = '0;
        drop_val          = '0;
        sc_eff            = sample_count_reg;

        if (stops.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (state_reg == S_SUM || state_reg == S_SUM_DRAIN)
        begin
            rd_word = rd_valid_reg ? drop_rdata : '0;
            if (acc_en_reg && rd_word != '0)
            begin
                sum_next   = sum_reg + {{(SUM_W-PRICE_W){1'b0}}, rd_word};
                count_next = count_reg + 1'b1;
            end
        end
        if (state_reg == S_MAX || state_reg == S_MAX_DRAIN)
        begin
            rd_word = rd_valid_reg ? cand_rdata : '0;
            if (acc_en_reg && rd_word > best_reg)
            begin
                best_next = rd_word;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (samples.series_start)
                    begin
                        sc_eff          = '0;
                        drop_valid_next = '0;
                        cand_valid_next = '0;
                        cand_wp_next    = '0;
                        drop_waddr      = '0;
                        sample_count_next = '0;
                    end
                    if (sc_eff != '0 && last_price_reg > samples.price)
                        drop_val = last_price_reg - samples.price;
                    drop_we         = 1'b1;
                    drop_wdata      = drop_val;
                    drop_valid_next[drop_waddr] = 1'b1;
                    drop_wp_next    = drop_waddr + 1'b1;
                    last_price_next = samples.price;
                    price_next      = samples.price;
                    sum_next        = '0;
                    count_next      = '0;
                    iter_next       = '0;
                    state_next      = S_SUM;
                end
            end
            S_SUM:
            begin
                acc_en_next   = 1'b1;
                rd_valid_next = drop_valid_reg[drop_raddr];
                iter_next     = iter_reg + 1'b1;
                if ({1'b0, iter_reg} == n1_eff - DROP_WIN_LO)
                    state_next = S_SUM_DRAIN;
            end
            S_SUM_DRAIN:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = multiplier_reg * sum_reg;
                state_next = (count_reg == '0) ? S_CAND : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                    state_next = S_CAND;
            end
            S_CAND:
            begin
                if (count_reg == '0)
                    cand_wdata = price_reg;
                else if (quotient >= {{(QUO_W-PRICE_W){1'b0}}, price_reg})
                    cand_wdata = '0;
                else
                    cand_wdata = price_reg - quotient[PRICE_W-1:0];
                cand_we         = 1'b1;
                cand_valid_next[cand_wp_reg] = 1'b1;
                cand_wp_next    = cand_wp_reg + 1'b1;
                if (sample_count_reg < SAMPLE_LIMIT)
                    sample_count_next = sample_count_reg + 1'b1;
                best_next  = '0;
                iter_next  = '0;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                acc_en_next   = 1'b1;
                rd_valid_next = cand_valid_reg[cand_raddr];
                iter_next     = iter_reg + 1'b1;
                if ({1'b0, iter_reg[CAND_AW-1:0]} == n2_eff - MAX_WIN_LO)
                    state_next = S_MAX_DRAIN;
            end
            S_MAX_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || stops.ready)
                begin
                    out_valid_next = 1'b1;
                    out_stop_next  = series_ready ? best_reg : '0;
                    out_rdy_next   = series_ready;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            drop_window_reg  <= DROP_WINDOW_RST;
            max_window_reg   <= MAX_WINDOW_RST;
            multiplier_reg   <= MULTIPLIER_RST;
            last_price_reg   <= '0;
            drop_wp_reg      <= '0;
            cand_wp_reg      <= '0;
            drop_valid_reg   <= '0;
            cand_valid_reg   <= '0;
            sample_count_reg <= '0;
            iter_reg         <= '0;
            acc_en_reg       <= 1'b0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            last_price_reg   <= last_price_next;
            drop_wp_reg      <= drop_wp_next;
            cand_wp_reg      <= cand_wp_next;
            drop_valid_reg   <= drop_valid_next;
            cand_valid_reg   <= cand_valid_next;
            sample_count_reg <= sample_count_next;
            iter_reg         <= iter_next;
            acc_en_reg       <= acc_en_next;
            rd_valid_reg     <= rd_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DROP_WINDOW: drop_window_reg <= cfg_data[DW_W-1:0];
                    REG_MAX_WINDOW:  max_window_reg  <= cfg_data[MW_W-1:0];
                    REG_MULTIPLIER:  multiplier_reg  <= cfg_data[MULT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        sum_reg      <= sum_next;
        count_reg    <= count_next;
        prod_reg     <= prod_next;
        best_reg     <= best_next;
        out_stop_reg <= out_stop_next;
        out_rdy_reg  <= out_rdy_next;
    end

    assign stops.valid      = out_valid_reg;
    assign stops.stop_level = out_stop_reg;
    assign stops.ready_res  = out_rdy_reg;

endmodule
